@@ rtl/core/rhs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RGBA4444 horizontal scaler package
// Shared field widths, payload structs, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package rhs_pkg;

   // Field and datapath widths.
   localparam int PIX_W     = 16;
   localparam int STEP_W    = 20;
   localparam int WID_W     = 12;
   localparam int POS_W     = 20;
   localparam int FRAC_BITS = 8;
   localparam int CH_W      = 4;
   localparam int CH_COUNT  = PIX_W / CH_W;
   localparam int KEY_W     = POS_W - FRAC_BITS;

   // At most this many results come from one request.
   localparam int MAX_RESULTS = 34;
   localparam int RUN_W       = 6;

   // Saturation value of the position accumulator.
   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

   // Configuration register indexes.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_STEP = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_WIDTH  = 1'b1;

   // Register reset values.
   localparam logic [STEP_W-1:0] STEP_RESET  = 20'd256;
   localparam logic [WID_W-1:0]  WIDTH_RESET = 12'd1;

   // Input request payload.
   typedef struct packed {
      logic [PIX_W-1:0] pixel_in;
      logic             last_in_row;
   } rhs_req_type;

   // Result payload.
   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic             last_of_run;
      logic             row_done;
      logic             bad_step;
   } rhs_rsp_type;

   // Sequencer states.
   typedef enum logic {
      RHS_IDLE,
      RHS_RUN
   } rhs_state_type;

endpackage
`default_nettype wire

@@ rtl/core/rhs_blend.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RGBA4444 blend unit
// Weights the left and right pixels by the 8-bit fraction, channel by channel.
// ----------------------------------------------------------------------------
module rhs_blend
   import rhs_pkg::*;
(
   input  wire logic [PIX_W-1:0]     left_pixel,
   input  wire logic [PIX_W-1:0]     right_pixel,
   input  wire logic [FRAC_BITS-1:0] frac,
   output logic [PIX_W-1:0]          blend_pixel
);

   localparam int WT_W  = FRAC_BITS + 1;
   localparam int SUM_W = CH_W + WT_W;

   logic [WT_W-1:0] left_weight;
   logic [WT_W-1:0] right_weight;

   // A zero fraction gives the full weight to the left pixel, which is a copy.
   assign left_weight  = WT_W'(1 << FRAC_BITS) - WT_W'(frac);
   assign right_weight = WT_W'(frac);

   // Each channel is an independent weighted sum, truncated to 4 bits.
   always_comb begin
      logic [SUM_W-1:0] sum;
      blend_pixel = '0;
      for (int ch = 0; ch < CH_COUNT; ch++) begin
         sum = SUM_W'(left_pixel[ch*CH_W +: CH_W]) * SUM_W'(left_weight)
             + SUM_W'(right_pixel[ch*CH_W +: CH_W]) * SUM_W'(right_weight);
         blend_pixel[ch*CH_W +: CH_W] = sum[FRAC_BITS +: CH_W];
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/rhs_gate.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Output gate
// Decides whether the output at a given position can be produced now.
// ----------------------------------------------------------------------------
module rhs_gate
   import rhs_pkg::*;
#(
   parameter int IDX_W = 11
) (
   input  wire logic [POS_W-1:0] position,
   input  wire logic [WID_W-1:0] count,
   input  wire logic [RUN_W-1:0] run_count,
   input  wire logic [IDX_W-1:0] source_index,
   input  wire logic             row_last,
   input  wire logic [WID_W-1:0] out_width,
   output logic                  go
);

   localparam int CMP_W = ((IDX_W > KEY_W) ? IDX_W : KEY_W) + 1;

   logic [CMP_W-1:0] key;
   logic [CMP_W-1:0] index;
   logic             frac_zero;
   logic             sources_in;

   assign key       = CMP_W'(position[POS_W-1:FRAC_BITS]);
   assign index     = CMP_W'(source_index);
   assign frac_zero = (position[FRAC_BITS-1:0] == '0);

   // Both source pixels must have arrived, unless the row is ending.
   assign sources_in = row_last || (frac_zero ? (key <= index) : (key < index));

   assign go = (count < out_width) && (run_count < RUN_W'(MAX_RESULTS)) && sources_in;

endmodule
`default_nettype wire

@@ rtl/core/rgba4444_horizontal_scaler_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RGBA4444 horizontal scaler
// Scales a row of RGBA4444 pixels by linear interpolation with 8 fraction bits.
// ----------------------------------------------------------------------------
// A request is accepted in the idle state and then produces its results one by
// one in the run state (it still passes through the run state when it produces
// none); req_ready is low until the sequencer returns to idle. The single blend
// unit produces one output pixel per cycle under the sequencer while the result
// side keeps up.
// A held result stalls the sequencer only, and up to 34 results follow one
// request. Configuration must be written only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module rgba4444_horizontal_scaler_top
   import rhs_pkg::*;
#(
   parameter int MAX_WIDTH   = 2048,
   parameter int MAX_UPSCALE = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire rhs_req_type          req_payload,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rhs_rsp_type               rsp_payload,
   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [STEP_W-1:0]    csr_write_data
);

   localparam int IDX_W = $clog2(MAX_WIDTH);
   localparam int CMP_W = ((IDX_W > KEY_W) ? IDX_W : KEY_W) + 1;
   localparam logic [STEP_W-1:0] MIN_STEP = STEP_W'((1 << FRAC_BITS) / MAX_UPSCALE);
   localparam logic [IDX_W-1:0]  IDX_MAX  = IDX_W'(MAX_WIDTH - 1);

   rhs_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [WID_W-1:0]  width_ff, width_in;
   logic [PIX_W-1:0]  prev_ff, prev_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [WID_W-1:0]  cnt_ff, cnt_in;
   logic [RUN_W-1:0]  run_ff, run_in;
   logic [PIX_W-1:0]  cur_ff, cur_in;
   logic              last_ff, last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rhs_rsp_type       rsp_payload_ff, rsp_payload_in;

   logic              accept;
   logic              bad;
   logic [STEP_W-1:0] step_eff;
   logic [POS_W:0]    pos_sum;
   logic [POS_W-1:0]  pos_next;
   logic [WID_W-1:0]  cnt_next;
   logic [RUN_W-1:0]  run_next;
   logic              go_now;
   logic              go_ahead;
   logic              slot_free;
   logic              emit;
   logic              finish;
   logic [CMP_W-1:0]  key_plus;
   logic [PIX_W-1:0]  left_pixel;
   logic [PIX_W-1:0]  blend_pixel;

   // Step clamping at the upscale limit.
   assign bad      = (step_ff < MIN_STEP);
   assign step_eff = bad ? MIN_STEP : step_ff;

   // Position, count and run advance for the next output.
   assign pos_sum  = {1'b0, pos_ff} + {1'b0, step_eff};
   assign pos_next = pos_sum[POS_W] ? POS_MAX : pos_sum[POS_W-1:0];
   assign cnt_next = cnt_ff + WID_W'(1);
   assign run_next = run_ff + RUN_W'(1);

   // Gate for the current output.
   rhs_gate #(
      .IDX_W (IDX_W)
   ) u_gate_now (
      .position     (pos_ff),
      .count        (cnt_ff),
      .run_count    (run_ff),
      .source_index (idx_ff),
      .row_last     (last_ff),
      .out_width    (width_ff),
      .go           (go_now)
   );

   // Gate for the output after it, which decides the end-of-run flag.
   rhs_gate #(
      .IDX_W (IDX_W)
   ) u_gate_ahead (
      .position     (pos_next),
      .count        (cnt_next),
      .run_count    (run_next),
      .source_index (idx_ff),
      .row_last     (last_ff),
      .out_width    (width_ff),
      .go           (go_ahead)
   );

   // The left pixel is the previous one when it sits just behind the newest.
   assign key_plus   = CMP_W'(pos_ff[POS_W-1:FRAC_BITS]) + CMP_W'(1);
   assign left_pixel = (key_plus == CMP_W'(idx_ff)) ? prev_ff : cur_ff;

   // Shared blend unit.
   rhs_blend u_blend (
      .left_pixel  (left_pixel),
      .right_pixel (cur_ff),
      .frac        (pos_ff[FRAC_BITS-1:0]),
      .blend_pixel (blend_pixel)
   );

   // Handshake and sequencing conditions.
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign emit      = (state_ff == RHS_RUN) && go_now && slot_free;
   assign finish    = (state_ff == RHS_RUN) && (!go_now || (slot_free && !go_ahead));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         RHS_IDLE: begin
            if (accept) begin
               state_in = RHS_RUN;
            end
         end
         RHS_RUN: begin
            if (finish) begin
               state_in = RHS_IDLE;
            end
         end
         default: begin
            state_in = RHS_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      case (state_ff)
         RHS_IDLE: req_ready = 1'b1;
         RHS_RUN:  req_ready = 1'b0;
         default:  req_ready = 1'b0;
      endcase
   end

   // Configuration registers.
   always_comb begin
      step_in  = step_ff;
      width_in = width_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_SCALE_STEP: step_in  = csr_write_data;
            CSR_OUT_WIDTH:  width_in = csr_write_data[WID_W-1:0];
            default: begin
               step_in  = step_ff;
               width_in = width_ff;
            end
         endcase
      end
   end

   // Request capture, row state and result register.
   always_comb begin
      cur_in         = cur_ff;
      last_in        = last_ff;
      run_in         = run_ff;
      prev_in        = prev_ff;
      idx_in         = idx_ff;
      pos_in         = pos_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;

      if (accept) begin
         cur_in  = req_payload.pixel_in;
         last_in = req_payload.last_in_row;
         run_in  = '0;
      end

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (emit) begin
         rsp_valid_in               = 1'b1;
         rsp_payload_in.pixel_out   = blend_pixel;
         rsp_payload_in.last_of_run = !go_ahead;
         rsp_payload_in.row_done    = (cnt_next >= width_ff) || (last_ff && !go_ahead);
         rsp_payload_in.bad_step    = bad;
         pos_in                     = pos_next;
         cnt_in                     = cnt_next;
         run_in                     = run_next;
      end

      // End of request: the row state moves on or returns to the row start.
      if (finish) begin
         prev_in = cur_ff;
         if (last_ff) begin
            idx_in = '0;
            pos_in = '0;
            cnt_in = '0;
         end else if (idx_ff < IDX_MAX) begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end
   end

   // Control and row state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= RHS_IDLE;
         step_ff      <= STEP_RESET;
         width_ff     <= WIDTH_RESET;
         prev_ff      <= '0;
         idx_ff       <= '0;
         pos_ff       <= '0;
         cnt_ff       <= '0;
         run_ff       <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         width_ff     <= width_in;
         prev_ff      <= prev_in;
         idx_ff       <= idx_in;
         pos_ff       <= pos_in;
         cnt_ff       <= cnt_in;
         run_ff       <= run_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // An accepted request lowers req_ready in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted but sequencer stayed idle");

   // No request gives more results than the run limit.
   assert property (@(posedge clock) disable iff (reset)
      run_ff <= RUN_W'(MAX_RESULTS))
      else $error("result run exceeded its limit");

   // A shown result carries the step flag of the current configuration.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.bad_step == bad))
      else $error("bad_step does not match the configured step");

   // A result is produced only while the block is working on a request.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid)) |-> $past(state_ff == RHS_RUN))
      else $error("result appeared outside a request");

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGBA4444 horizontal scaler testbench
// Streams rows of source pixels through the scaler under several step and
// width settings and checks every output pixel and flag against a cycle-free
// model of the interpolation, with random idling on both handshakes.
// ----------------------------------------------------------------------------
module testbench;
   import rhs_pkg::*;

   localparam int SCALER_MAX_WIDTH = 2048;
   localparam int UPSCALE_LIMIT    = 16;
   localparam int CYCLE_LIMIT      = 1000000;
   localparam int PHASE_REQUESTS   = 107;

   // Model of the scaler: row state, register copies and pending outputs.
   class scaler_scoreboard;
      logic [STEP_W-1:0] step_reg;
      logic [WID_W-1:0]  width_reg;
      logic [PIX_W-1:0]  prev_pixel;
      int unsigned       src_index;
      int unsigned       position;
      int unsigned       out_count;
      rhs_rsp_type       pending_pixels[$];
      int                errors;

      function new();
         step_reg   = STEP_RESET;
         width_reg  = WIDTH_RESET;
         prev_pixel = '0;
         src_index  = 0;
         position   = 0;
         out_count  = 0;
         errors     = 0;
      endfunction

      function void write_register(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [STEP_W-1:0] data);
         case (idx)
            CSR_SCALE_STEP: begin
               step_reg = data;
            end
            CSR_OUT_WIDTH: begin
               width_reg = data[WID_W-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      // Each 4-bit channel is weighted by the fraction and truncated.
      function logic [PIX_W-1:0] mix_pixels(input logic [PIX_W-1:0] left,
                                            input logic [PIX_W-1:0] right,
                                            input int unsigned frac);
         logic [PIX_W-1:0] mixed;
         int unsigned lc;
         int unsigned rc;
         int unsigned sum;
         int ch;
         mixed = '0;
         for (ch = 0; ch < CH_COUNT; ch++) begin
            lc  = left[ch*CH_W +: CH_W];
            rc  = right[ch*CH_W +: CH_W];
            sum = (lc * (256 - frac) + rc * frac) >> FRAC_BITS;
            mixed[ch*CH_W +: CH_W] = sum[CH_W-1:0];
         end
         return mixed;
      endfunction

      // Works out every output pixel that this source pixel completes.
      function void note_request(input rhs_req_type req);
         logic [PIX_W-1:0] cur;
         logic [PIX_W-1:0] left;
         bit          last;
         bit          bad;
         bit          ready;
         int unsigned advance;
         int unsigned k;
         int unsigned f;
         int unsigned nxt;
         int          n;
         rhs_rsp_type r;
         cur     = req.pixel_in;
         last    = req.last_in_row;
         bad     = step_reg < (256 / UPSCALE_LIMIT);
         advance = bad ? (256 / UPSCALE_LIMIT) : step_reg;
         n       = 0;
         while (out_count < width_reg && n < MAX_RESULTS) begin
            k = position >> FRAC_BITS;
            f = position & 8'hFF;
            ready = last || ((f == 0) ? (k <= src_index) : (k < src_index));
            if (!ready) break;
            left = (k + 1 == src_index) ? prev_pixel : cur;
            out_count++;
            r.pixel_out   = (f == 0) ? left : mix_pixels(left, cur, f);
            r.last_of_run = 1'b0;
            r.row_done    = (out_count >= width_reg);
            r.bad_step    = bad;
            pending_pixels.push_back(r);
            n++;
            nxt = position + advance;
            position = (nxt > POS_MAX) ? POS_MAX : nxt;
         end
         // The final output of a request closes the run, and the row on its end.
         if (n > 0) begin
            r = pending_pixels.pop_back();
            r.last_of_run = 1'b1;
            if (last) r.row_done = 1'b1;
            pending_pixels.push_back(r);
         end
         prev_pixel = cur;
         if (last) begin
            src_index = 0;
            position  = 0;
            out_count = 0;
         end else if (src_index < SCALER_MAX_WIDTH - 1) begin
            src_index++;
         end
      endfunction

      function void check_result(input rhs_rsp_type got);
         rhs_rsp_type exp;
         if (pending_pixels.size() == 0) begin
            $error("unexpected output pixel %h", got.pixel_out);
            errors++;
            return;
         end
         exp = pending_pixels.pop_front();
         if (got.pixel_out !== exp.pixel_out) begin
            $error("pixel_out: expected %h, actual %h", exp.pixel_out, got.pixel_out);
            errors++;
         end
         if (got.last_of_run !== exp.last_of_run) begin
            $error("last_of_run: expected %b, actual %b", exp.last_of_run,
                   got.last_of_run);
            errors++;
         end
         if (got.row_done !== exp.row_done) begin
            $error("row_done: expected %b, actual %b", exp.row_done, got.row_done);
            errors++;
         end
         if (got.bad_step !== exp.bad_step) begin
            $error("bad_step: expected %b, actual %b", exp.bad_step, got.bad_step);
            errors++;
         end
      endfunction

      function bit drained();
         return pending_pixels.size() == 0;
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   rhs_req_type          req_payload;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rhs_rsp_type          rsp_payload;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [STEP_W-1:0]    csr_write_data;

   scaler_scoreboard sb;
   int               send_idle_pct = 16;
   int               recv_idle_pct = 61;
   int               hold_off_request = 0;
   int               random_requests = 0;
   int               cycle_count = 0;

   rgba4444_horizontal_scaler_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side: random back-pressure, and long hold-offs on demand.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request > 0) begin
            stall_left = hold_off_request;
            hold_off_request = 0;
         end
         if (reset !== 1'b0) begin
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Every accepted output pixel is checked against the oldest prediction.
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         sb.check_result(rsp_payload);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Offers one source pixel and returns at the edge where it is accepted.
   // Valid is left high so that the next request can follow without a gap.
   task automatic send_pixel(input logic [PIX_W-1:0] pix, input bit last);
      rhs_req_type req;
      req.pixel_in    = pix;
      req.last_in_row = last;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= req;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_request(req);
   endtask

   task automatic send_random_row(input int len, input bit counted);
      int i;
      for (i = 0; i < len; i++) begin
         send_pixel($urandom, i == len - 1);
         if (counted) random_requests++;
      end
   endtask

   // Stops offering and waits until every predicted pixel has come out, then
   // lets a request without outputs finish inside the block.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (!sb.drained()) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes the step register and then the width register; only called while idle.
   task automatic configure(input int unsigned step, input int unsigned width);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_SCALE_STEP;
      csr_write_data   <= step[STEP_W-1:0];
      @(posedge clock);
      csr_index        <= CSR_OUT_WIDTH;
      csr_write_data   <= {{(STEP_W-WID_W){1'b0}}, width[WID_W-1:0]};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.write_register(CSR_SCALE_STEP, step[STEP_W-1:0]);
      sb.write_register(CSR_OUT_WIDTH, {{(STEP_W-WID_W){1'b0}}, width[WID_W-1:0]});
   endtask

   // One random row: usually a new setting, mostly a step that matches the row length,
   // otherwise a random, too small or arbitrary one; sometimes the old setting.
   task automatic random_row();
      int unsigned reach;
      int unsigned in_w;
      int unsigned out_w;
      int unsigned step;
      int unsigned mode;
      reach = $urandom_range(99);
      if (reach < 75) in_w = $urandom_range(1, 16);
      else if (reach < 95) in_w = $urandom_range(17, 48);
      else in_w = $urandom_range(49, 120);
      if ($urandom_range(99) < 70) begin
         mode = $urandom_range(9);
         if (mode < 7) begin
            if ($urandom_range(3) == 0) out_w = $urandom_range(1, in_w * 16);
            else out_w = $urandom_range(1, in_w * 2 + 2);
            if (out_w > 2048) out_w = 2048;
            step = (in_w * 256) / out_w;
         end else if (mode == 7) begin
            step  = $urandom_range(16, 2048);
            out_w = $urandom_range(1, 64);
         end else if (mode == 8) begin
            step  = $urandom_range(0, 15);
            out_w = $urandom_range(1, 48);
         end else begin
            step  = $urandom_range(0, 20'hFFFFF);
            out_w = $urandom_range(0, 12'hFFF);
         end
         wait_idle();
         configure(step, out_w);
      end
      send_random_row(in_w, 1'b1);
   endtask

   // Stimulus.
   initial begin
      int phase;
      sb = new();
      req_valid        <= 1'b0;
      req_payload      <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_SCALE_STEP;
      csr_write_data   <= '0;
      reset            <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Register values after reset: one copied pixel per row.
      send_pixel(16'h0000, 1'b0);
      send_pixel(16'hFFFF, 1'b1);

      // Unit step: straight copies.
      wait_idle();
      configure(256, 4);
      send_pixel(16'hFFFF, 1'b0);
      send_pixel(16'h0000, 1'b0);
      send_pixel(16'hA5C3, 1'b0);
      send_pixel(16'h5A3C, 1'b1);

      // Full 16x upscale while the result side holds off for a long time.
      wait_idle();
      configure(16, 40);
      hold_off_request = 300;
      send_pixel(16'hF0F0, 1'b0);
      send_pixel(16'h0F0F, 1'b0);
      send_pixel(16'hFFFF, 1'b1);

      // A zero step is too small and is flagged.
      wait_idle();
      configure(0, 5);
      send_pixel(16'h1234, 1'b0);
      send_pixel(16'h8765, 1'b1);

      // Too small step with the widest row: the row end hits the result limit.
      wait_idle();
      configure(15, 2048);
      send_pixel(16'hFFFF, 1'b0);
      send_pixel(16'h0000, 1'b0);
      send_pixel(16'hFFFF, 1'b1);

      // Largest step: the position saturates, outputs past the row end copy
      // the last pixel.
      wait_idle();
      configure(20'hFFFFF, 6);
      send_pixel(16'h0001, 1'b0);
      send_pixel(16'h8000, 1'b0);
      send_pixel(16'h7FFE, 1'b1);

      wait_idle();
      configure(524288, 3);
      send_pixel(16'hC3A5, 1'b0);
      send_pixel(16'h3C5A, 1'b1);

      // A zero output width gives no outputs at all.
      wait_idle();
      configure(384, 0);
      send_pixel(16'h1111, 1'b0);
      send_pixel(16'h2222, 1'b0);
      send_pixel(16'h3333, 1'b1);

      // Row already complete: extra source pixels give nothing.
      wait_idle();
      configure(256, 2);
      send_pixel(16'h4444, 1'b0);
      send_pixel(16'h5555, 1'b0);
      send_pixel(16'h6666, 1'b1);

      // Random rows under the three idling schemes.
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 16;
               recv_idle_pct = 61;
            end
            1: begin
               send_idle_pct = 61;
               recv_idle_pct = 16;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         while (random_requests < PHASE_REQUESTS * (phase + 1)) random_row();
      end

      req_valid <= 1'b0;
      while (!sb.drained()) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
